// File: sv/fvn_pkg.sv
`timescale 1ns / 1ps
package fvn_pkg;

  // register indexes of the configuration port
  typedef enum logic [1:0] {
    REG_FREQUENCY    = 2'd0,
    REG_OCTAVE_COUNT = 2'd1,
    REG_SEED_OFFSET  = 2'd2
  } reg_idx_e;

  localparam int unsigned MaxOctaves     = 8;
  localparam int unsigned PosW           = 48;
  localparam int unsigned SumW           = 34;
  localparam int unsigned CellStages     = 8;
  localparam logic [31:0] HashBase       = 32'd1337;
  localparam logic [31:0] OctaveSeedStep = 32'd9973;
  localparam logic [31:0] MixX           = 32'h9E3779B9;
  localparam logic [31:0] MixZ           = 32'h85EBCA6B;
  localparam logic [31:0] MixA           = 32'h7FEB352D;
  localparam logic [31:0] MixB           = 32'h846CA68B;

  localparam logic [15:0] FrequencyReset   = 16'd328;
  localparam logic [3:0]  OctaveCountReset = 4'd6;

  // what one cell hands to the next
  typedef struct packed {
    logic                   valid;
    logic [PosW-1:0]        px;
    logic [PosW-1:0]        pz;
    logic signed [SumW-1:0] sum;
  } hop_t;

endpackage

// File: sv/fvn_cell.sv
`timescale 1ns / 1ps
module fvn_cell #(
  parameter int unsigned K       = 0,
  parameter int unsigned MAX_OCT = fvn_pkg::MaxOctaves
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             en_i,
  input  logic [$clog2(MAX_OCT+1)-1:0]     n_eff_i,
  input  logic [31:0]                      seed_offset_i,
  input  fvn_pkg::hop_t                    hop_i,
  output fvn_pkg::hop_t                    hop_o
);
  import fvn_pkg::*;

  localparam int unsigned NW = $clog2(MAX_OCT+1);
  localparam logic [31:0] SeedConst = 32'(HashBase + 32'(K) * OctaveSeedStep);
  localparam int unsigned Shift = 16 - K;

  logic [31:0] seed;
  assign seed = seed_offset_i + SeedConst;

  // stage 0: lattice products and fraction squares
  logic [31:0] cx, cz, cx1, cz1;
  logic [31:0] mx_q [2];
  logic [31:0] mz_q [2];
  logic [15:0] fx_q, fz_q;
  logic [31:0] ffx_q, ffz_q;
  assign cx  = hop_i.px[47:16];
  assign cz  = hop_i.pz[47:16];
  assign cx1 = cx + 32'd1;
  assign cz1 = cz + 32'd1;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mx_q[0] <= 32'(cx * MixX);
      mx_q[1] <= 32'(cx1 * MixX);
      mz_q[0] <= 32'(cz * MixZ);
      mz_q[1] <= 32'(cz1 * MixZ);
      fx_q    <= hop_i.px[15:0];
      fz_q    <= hop_i.pz[15:0];
      ffx_q   <= 32'(hop_i.px[15:0] * hop_i.px[15:0]);
      ffz_q   <= 32'(hop_i.pz[15:0] * hop_i.pz[15:0]);
    end
  end

  // stage 1: seed mix and first multiply, smoothstep product
  logic [31:0] h1_d [4];
  logic [31:0] h1_q [4];
  logic [49:0] wpx_q, wpz_q;
  logic [17:0] tx, tz;
  assign tx = 18'd196608 - {1'b0, fx_q, 1'b0};
  assign tz = 18'd196608 - {1'b0, fz_q, 1'b0};

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      logic [31:0] h;
      h = seed ^ mx_q[c % 2];
      h = {h[18:0], h[31:19]};
      h = h ^ mz_q[c / 2];
      h = h ^ (h >> 16);
      h1_d[c] = 32'(h * MixA);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      h1_q  <= h1_d;
      wpx_q <= 50'(ffx_q * tx);
      wpz_q <= 50'(ffz_q * tz);
    end
  end

  // stage 2: second multiply, weights
  logic [31:0] h2_q [4];
  logic [15:0] wx2_q, wz2_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        h2_q[c] <= 32'((h1_q[c] ^ (h1_q[c] >> 15)) * MixB);
      end
      wx2_q <= wpx_q[47:32];
      wz2_q <= wpz_q[47:32];
    end
  end

  // stage 3: corner samples
  logic signed [15:0] smp_q [4];
  logic [15:0] wx3_q, wz3_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int c = 0; c < 4; c++) begin
        logic [31:0] h;
        h = h2_q[c] ^ (h2_q[c] >> 16);
        smp_q[c] <= {~h[31], h[30:16]};
      end
      wx3_q <= wx2_q;
      wz3_q <= wz2_q;
    end
  end

  // stage 4: x blend products
  logic signed [33:0] pa_q, pb_q;
  logic signed [16:0] s0_q, s2_q;
  logic [15:0] wz4_q;
  logic signed [16:0] dx0, dx1, wxs;
  assign dx0 = 17'(smp_q[1]) - 17'(smp_q[0]);
  assign dx1 = 17'(smp_q[3]) - 17'(smp_q[2]);
  assign wxs = $signed({1'b0, wx3_q});
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pa_q  <= dx0 * wxs;
      pb_q  <= dx1 * wxs;
      s0_q  <= 17'(smp_q[0]);
      s2_q  <= 17'(smp_q[2]);
      wz4_q <= wz3_q;
    end
  end

  // stage 5: x blend sums
  logic signed [16:0] a_q, b_q;
  logic [15:0] wz5_q;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      a_q   <= s0_q + 17'(pa_q >>> 16);
      b_q   <= s2_q + 17'(pb_q >>> 16);
      wz5_q <= wz4_q;
    end
  end

  // stage 6: z blend product
  logic signed [34:0] pab_q;
  logic signed [16:0] a6_q;
  logic signed [17:0] dab;
  assign dab = 18'(b_q) - 18'(a_q);
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      pab_q <= dab * $signed({1'b0, wz5_q});
      a6_q  <= a_q;
    end
  end

  // side band delay for position, sum and valid
  logic [CellStages-1:0] vld_q;
  hop_t dly_q [CellStages-1];
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en_i) begin
      vld_q <= {vld_q[CellStages-2:0], hop_i.valid};
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      dly_q[0] <= '{valid: 1'b0, px: {hop_i.px[PosW-2:0], 1'b0},
                    pz: {hop_i.pz[PosW-2:0], 1'b0}, sum: hop_i.sum};
      for (int i = 1; i < CellStages - 1; i++) dly_q[i] <= dly_q[i-1];
    end
  end

  // stage 7: octave value, weighted accumulate
  logic signed [16:0] v;
  logic active;
  logic signed [SumW-1:0] term;
  logic [PosW-1:0] px_q, pz_q;
  logic signed [SumW-1:0] sum_q;
  assign v      = a6_q + 17'(pab_q >>> 16);
  assign active = (NW'(K) < n_eff_i);
  assign term   = active ? (SumW'(v) <<< Shift) : '0;
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      px_q  <= dly_q[CellStages-2].px;
      pz_q  <= dly_q[CellStages-2].pz;
      sum_q <= dly_q[CellStages-2].sum + term;
    end
  end

  assign hop_o = '{valid: vld_q[CellStages-1], px: px_q, pz: pz_q, sum: sum_q};

endmodule

// File: sv/fractal_value_noise_top.sv
`timescale 1ns / 1ps
// Fractal value noise: one (x_coord, z_coord) transaction in, one noise_value out.
// A new coordinate pair is taken every clock unless a finished result is blocked at the output.
// Data passes the input scale multiply, MAX_OCTAVES octave cells, each an 8-stage hash and blend
// pipeline, the normalize multiply and the output register. Octaves at or above the programmed
// octave_count add nothing; octave_count of 0 returns 0. The user must write configuration via
// cfg_we_i/cfg_addr_i/cfg_wdata_i only while no transaction is in flight; the block does not enforce it.
module fractal_value_noise_top #(
  parameter int unsigned MAX_OCTAVES = fvn_pkg::MaxOctaves
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [23:0] x_coord_i,
  input  logic signed [23:0] z_coord_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [15:0] noise_value_o
);
  import fvn_pkg::*;

  localparam int unsigned NW = $clog2(MAX_OCTAVES+1);

  // configuration registers
  logic [15:0] freq_q;
  logic [3:0]  oct_q;
  logic [31:0] seed_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      freq_q <= FrequencyReset;
      oct_q  <= OctaveCountReset;
      seed_q <= '0;
    end else if (cfg_we_i) begin
      unique case (cfg_addr_i)
        REG_FREQUENCY:    freq_q <= cfg_wdata_i[15:0];
        REG_OCTAVE_COUNT: oct_q  <= cfg_wdata_i[3:0];
        REG_SEED_OFFSET:  seed_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // clamped octave count
  logic [NW-1:0] n_eff;
  always_comb begin
    if (32'(oct_q) > MAX_OCTAVES) n_eff = NW'(MAX_OCTAVES);
    else n_eff = NW'(oct_q);
  end

  // pipeline advance
  logic en, n0_vld_q, out_vld_q;
  assign en         = !out_vld_q || out_ready_i || !n0_vld_q;
  assign in_ready_o = en;

  // input scale
  hop_t hop [MAX_OCTAVES+1];
  logic p0_vld_q;
  logic signed [40:0] px0_q, pz0_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) p0_vld_q <= 1'b0;
    else if (en) p0_vld_q <= in_valid_i;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      px0_q <= x_coord_i * $signed({1'b0, freq_q});
      pz0_q <= z_coord_i * $signed({1'b0, freq_q});
    end
  end
  assign hop[0] = '{valid: p0_vld_q, px: PosW'(px0_q), pz: PosW'(pz0_q), sum: '0};

  // octave cells
  for (genvar g = 0; g < MAX_OCTAVES; g++) begin : g_cell
    fvn_cell #(.K(g), .MAX_OCT(MAX_OCTAVES)) u_cell (
      .clk_i, .rst_ni, .en_i(en), .n_eff_i(n_eff), .seed_offset_i(seed_q),
      .hop_i(hop[g]), .hop_o(hop[g+1])
    );
  end

  // reciprocal of total amplitude per octave count
  logic [16:0] recip_tab [MAX_OCTAVES+1];
  assign recip_tab[0] = '0;
  for (genvar n = 1; n <= MAX_OCTAVES; n++) begin : g_recip
    localparam longint unsigned Tot = (64'd1 << 17) - (64'd1 << (17 - n));
    localparam longint unsigned Rc  = ((64'd1 << 32) + Tot / 2) / Tot;
    assign recip_tab[n] = 17'(Rc);
  end

  // normalize multiply
  logic signed [51:0] prod_q;
  logic zero_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) n0_vld_q <= 1'b0;
    else if (en) n0_vld_q <= hop[MAX_OCTAVES].valid;
  end
  always_ff @(posedge clk_i) begin
    if (en) begin
      prod_q <= 52'(hop[MAX_OCTAVES].sum * $signed({1'b0, recip_tab[n_eff]}));
      zero_q <= (n_eff == '0);
    end
  end

  // round, saturate, output register
  logic signed [19:0] r;
  logic signed [15:0] res_d, res_q;
  assign r = 20'((prod_q + 52'sd2147483648) >>> 32);
  always_comb begin
    priority if (zero_q) res_d = '0;
    else if (r > 20'sd32767) res_d = 16'sd32767;
    else if (r < -20'sd32768) res_d = -16'sd32768;
    else res_d = 16'(r);
  end

  logic load;
  assign load = n0_vld_q && (!out_vld_q || out_ready_i);
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_vld_q <= 1'b0;
    else if (load) out_vld_q <= 1'b1;
    else if (out_ready_i) out_vld_q <= 1'b0;
  end
  always_ff @(posedge clk_i) begin
    if (load) res_q <= res_d;
  end
  assign out_valid_o   = out_vld_q;
  assign noise_value_o = res_q;

  // checks
  a_stall_only_on_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_o |-> (out_vld_q && !out_ready_i && n0_vld_q))
    else $error("input stalled without a blocked result");
  a_final_lands: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (n0_vld_q && en) |=> out_vld_q)
    else $error("finished result dropped");
  a_held_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_vld_q && !out_ready_i) |=> (out_vld_q && $stable(res_q)))
    else $error("waiting result changed");

endmodule
